// ===== design/session_cache_direct_mapped_ttl_unit_macros.svh =====
// ----------------------------------------------------------------------------
// session cache assertion macros
// shared property forms for the checker of the session cache
// ----------------------------------------------------------------------------
`ifndef SESSION_CACHE_DIRECT_MAPPED_TTL_UNIT_MACROS_SVH
`define SESSION_CACHE_DIRECT_MAPPED_TTL_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCDM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SCDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== design/scdm_pkg.sv =====
// ----------------------------------------------------------------------------
// session cache package
// types, codes and constants shared by the session cache modules
// ----------------------------------------------------------------------------
`default_nettype none

package scdm_pkg;

	localparam logic [31:0] HASH_MUL       = 32'h9e37_79b1;
	localparam logic [30:0] LIFETIME_RESET = 31'(24 * 60 * 60);
	localparam int          KEY_BYTES      = 32;
	localparam int          IN_TDATA_W     = 416;
	localparam int          OUT_TDATA_W    = 112;

	typedef enum logic [2:0] {
		ST_STORED     = 3'd0,
		ST_HIT        = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_COLLISION  = 3'd3,
		ST_EXPIRED    = 3'd4,
		ST_CERT_BIG   = 3'd5,
		ST_TICKET_BIG = 3'd6
	} status_t;

	// what the front decided an item is
	typedef enum logic [1:0] {
		OP_STORE,
		OP_LOOKUP,
		OP_CERT_BIG,
		OP_TICKET_BIG
	} op_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_HASH,
		FR_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_WRITE,
		BK_DECIDE,
		BK_REPLY
	} back_state_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [15:0] ticket_bytes_in;
		logic [15:0] cert_bytes_in;
		logic [63:0] payload_in;
		logic [31:0] now_seconds;
		logic [63:0] key_word3;
		logic [63:0] key_word2;
		logic [63:0] key_word1;
		logic [63:0] key_word0;
		logic [5:0]  key_length;
		logic [7:0]  compression_method;
		logic [15:0] cipher_suite;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  pad;
		logic [15:0] ticket_bytes_out;
		logic [15:0] cert_bytes_out;
		logic [63:0] payload_out;
		logic [7:0]  slot_index;
		status_t     status;
	} out_word_t;

	// one classified item between front and back
	typedef struct packed {
		op_t          op;
		logic [15:0]  suite;
		logic [7:0]   comp;
		logic [5:0]   key_length;
		logic [255:0] key;
		logic [31:0]  now;
		logic [63:0]  payload;
		logic [15:0]  cert_bytes;
		logic [15:0]  ticket_bytes;
		logic [31:0]  hash;
	} job_t;

	typedef struct packed {
		logic [31:0]  hash;
		logic [15:0]  suite;
		logic [7:0]   comp;
		logic [5:0]   key_length;
		logic [255:0] key;
		logic [31:0]  stamp;
		logic [63:0]  payload;
		logic [15:0]  cert_bytes;
		logic [15:0]  ticket_bytes;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic hash_eq;
		logic key_eq;
		logic early;
		logic late;
	} check_t;

endpackage

`default_nettype wire

// ===== design/scdm_fifo.sv =====
// ----------------------------------------------------------------------------
// session cache job queue
// two-entry queue that lets the hash front and the table back stall apart
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_fifo
	import scdm_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic push,
	input  job_t       push_data,
	output logic       full,
	input  wire  logic pop,
	output job_t       pop_data,
	output logic       empty
);

	job_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/scdm_front.sv =====
// ----------------------------------------------------------------------------
// session cache front
// takes one word, masks the id, runs the byte-serial hash and classifies
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_front
	import scdm_pkg::*;
#(
	parameter int CERT_MAX_BYTES   = 4096,
	parameter int TICKET_MAX_BYTES = 1024
) (
	input  wire  logic     clk,
	input  wire  logic     arst_n,
	input  wire  logic     in_valid,
	output logic           in_ready,
	input  wire  logic     in_cmd,
	input  in_word_t       in_word,
	input  wire  logic     blocked,
	output logic           push,
	output job_t           push_data,
	input  wire  logic     full
);

	front_state_t state_q;
	front_state_t state_d;
	in_word_t     item_q;
	logic         cmd_q;
	logic [5:0]   len_q;
	logic [5:0]   cnt_q;
	logic [31:0]  hash_q;
	logic [255:0] key_q;
	logic [5:0]   len_d;
	logic [255:0] key_raw;
	logic [255:0] key_masked;
	logic [7:0]   cur_byte;
	logic         accept;
	op_t          op;

	assign accept   = in_valid && in_ready;
	assign key_raw  = {in_word.key_word3, in_word.key_word2,
		in_word.key_word1, in_word.key_word0};
	assign len_d    = (in_word.key_length > 6'd32) ? 6'd32 : in_word.key_length;
	assign cur_byte = key_q[{cnt_q[4:0], 3'b000} +: 8];

	// bytes at and beyond the clipped length never count
	always_comb begin
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_masked[b*8 +: 8] = (6'(b) < len_d) ? key_raw[b*8 +: 8] : 8'h00;
		end
	end

	always_comb begin
		if (cmd_q) begin
			op = OP_LOOKUP;
		end else if (item_q.cert_bytes_in > 16'(CERT_MAX_BYTES)) begin
			op = OP_CERT_BIG;
		end else if (item_q.ticket_bytes_in > 16'(TICKET_MAX_BYTES)) begin
			op = OP_TICKET_BIG;
		end else begin
			op = OP_STORE;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: begin
				if (accept) begin
					state_d = FR_HASH;
				end
			end
			FR_HASH: begin
				if (cnt_q == len_q) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!full) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			FR_IDLE: in_ready = !blocked;
			FR_HASH: in_ready = 1'b0;
			FR_PUSH: push     = !full;
			default: in_ready = 1'b0;
		endcase
	end

	always_comb begin
		push_data.op           = op;
		push_data.suite        = item_q.cipher_suite;
		push_data.comp         = item_q.compression_method;
		push_data.key_length   = item_q.key_length;
		push_data.key          = key_q;
		push_data.now          = item_q.now_seconds;
		push_data.payload      = item_q.payload_in;
		push_data.cert_bytes   = item_q.cert_bytes_in;
		push_data.ticket_bytes = item_q.ticket_bytes_in;
		push_data.hash         = hash_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// the suite is not hashed; the hash starts from the compression method
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
			cmd_q  <= in_cmd;
			len_q  <= len_d;
			key_q  <= key_masked;
			cnt_q  <= 6'd0;
			hash_q <= {24'd0, in_word.compression_method} * HASH_MUL;
		end else if (state_q == FR_HASH && cnt_q != len_q) begin
			hash_q <= (hash_q + {24'd0, cur_byte}) * HASH_MUL;
			cnt_q  <= cnt_q + 6'd1;
		end
	end

endmodule

`default_nettype wire

// ===== design/scdm_back.sv =====
// ----------------------------------------------------------------------------
// session cache back
// owns the slot table, runs store and lookup and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_back
	import scdm_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic [30:0] lifetime,
	input  wire  logic        empty,
	output logic              pop,
	input  job_t              pop_data,
	output logic              out_valid,
	input  wire  logic        out_ready,
	output out_word_t         out_word,
	output logic              clearing
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	back_state_t      state_q;
	back_state_t      state_d;
	job_t             job_q;
	check_t           chk_q;
	out_word_t        res_q;
	out_word_t        res_d;
	out_word_t        out_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] clr_q;
	entry_t           entry_mem [ENTRIES];
	logic             valid_mem [ENTRIES];
	entry_t           rd_entry_q;
	logic             rd_valid_q;
	logic [31:0]      slot_idx;
	logic [IDX_W-1:0] addr;
	logic             rd_en;
	logic             ent_we;
	entry_t           ent_wdata;
	logic             val_we;
	logic             val_wdata;
	logic [IDX_W-1:0] val_addr;
	logic             expire;
	logic             out_free;

	assign slot_idx  = job_q.hash & 32'(ENTRIES - 1);
	assign addr      = slot_idx[IDX_W-1:0];
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign val_addr  = clearing ? clr_q : addr;

	always_comb begin
		ent_wdata.hash         = job_q.hash;
		ent_wdata.suite        = job_q.suite;
		ent_wdata.comp         = job_q.comp;
		ent_wdata.key_length   = job_q.key_length;
		ent_wdata.key          = job_q.key;
		ent_wdata.stamp        = job_q.now;
		ent_wdata.payload      = job_q.payload;
		ent_wdata.cert_bytes   = job_q.cert_bytes;
		ent_wdata.ticket_bytes = job_q.ticket_bytes;
	end

	// result of the finished item, formed in the decide step
	always_comb begin
		res_d            = '0;
		res_d.slot_index = slot_idx[7:0];
		expire           = 1'b0;
		case (job_q.op)
			OP_STORE:      res_d.status = ST_STORED;
			OP_CERT_BIG:   res_d.status = ST_CERT_BIG;
			OP_TICKET_BIG: res_d.status = ST_TICKET_BIG;
			default: begin
				if (!chk_q.valid || !chk_q.hash_eq) begin
					res_d.status = ST_EMPTY;
				end else if (!chk_q.key_eq) begin
					res_d.status = ST_COLLISION;
				end else if (chk_q.early || chk_q.late) begin
					res_d.status = ST_EXPIRED;
					expire       = 1'b1;
				end else begin
					res_d.status           = ST_HIT;
					res_d.payload_out      = rd_entry_q.payload;
					res_d.cert_bytes_out   = rd_entry_q.cert_bytes;
					res_d.ticket_bytes_out = rd_entry_q.ticket_bytes;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == IDX_W'(ENTRIES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!empty) begin
					unique case (pop_data.op)
						OP_LOOKUP: state_d = BK_READ;
						OP_STORE:  state_d = BK_WRITE;
						default:   state_d = BK_DECIDE;
					endcase
				end
			end
			BK_READ:   state_d = BK_CHECK;
			BK_CHECK:  state_d = BK_DECIDE;
			BK_WRITE:  state_d = BK_DECIDE;
			BK_DECIDE: state_d = BK_REPLY;
			BK_REPLY: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		clearing  = 1'b0;
		rd_en     = 1'b0;
		ent_we    = 1'b0;
		val_we    = 1'b0;
		val_wdata = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				clearing = 1'b1;
				val_we   = 1'b1;
			end
			BK_IDLE: pop = !empty;
			BK_READ: rd_en = 1'b1;
			BK_WRITE: begin
				ent_we    = 1'b1;
				val_we    = 1'b1;
				val_wdata = 1'b1;
			end
			BK_DECIDE: val_we = expire;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[addr] <= ent_wdata;
		end
		if (rd_en) begin
			rd_entry_q <= entry_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			valid_mem[val_addr] <= val_wdata;
		end
		if (rd_en) begin
			rd_valid_q <= valid_mem[addr];
		end
	end

	// lifetime end is taken 33 bits wide so it never wraps
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_data;
		end
		if (state_q == BK_CHECK) begin
			chk_q.valid   <= rd_valid_q;
			chk_q.hash_eq <= (rd_entry_q.hash == job_q.hash);
			chk_q.key_eq  <= (rd_entry_q.suite == job_q.suite)
				&& (rd_entry_q.comp == job_q.comp)
				&& (rd_entry_q.key_length == job_q.key_length)
				&& (rd_entry_q.key == job_q.key);
			chk_q.early   <= (rd_entry_q.stamp > job_q.now);
			chk_q.late    <= ({1'b0, job_q.now}
				> ({1'b0, rd_entry_q.stamp} + {2'b00, lifetime}));
		end
		if (state_q == BK_DECIDE) begin
			res_q <= res_d;
		end
		if (state_q == BK_REPLY && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (state_q == BK_REPLY && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/session_cache_direct_mapped_ttl_unit.sv =====
// ----------------------------------------------------------------------------
// session cache, direct mapped, with entry lifetime
// store and lookup of session keys in a hashed slot table
// ----------------------------------------------------------------------------
// After reset the block sweeps all ENTRIES slots (256 by default) of the
// slot valid table, one slot a cycle, with s_axis_tready low; lifetime
// writes are taken meanwhile. Each word then passes the front in an accept
// step, the hash loop and a push step, where the multiplicative hash takes
// one session id byte per cycle, up to min(key_length,32) bytes. The back
// pops a word, reads and checks for a lookup, writes for a store or skips
// both for a rejected store, then loads the result register in the decide
// step, behind a two-word queue. The hash loop sets the sustained rate for
// keys of two bytes or more; for shorter keys the back does. A result
// waiting on m_axis_tready does not stop the front from taking and hashing
// the next word.
`default_nettype none

module session_cache_direct_mapped_ttl_unit
	import scdm_pkg::*;
#(
	parameter int ENTRIES          = 256,
	parameter int CERT_MAX_BYTES   = 4096,
	parameter int TICKET_MAX_BYTES = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [30:0]            cfg_wr_data,   // lifetime_seconds
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// cipher_suite, compression_method, key_length, key_word0..3,
	// now_seconds, payload_in, cert_bytes_in, ticket_bytes_in, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [0:0]             s_axis_tuser,  // cmd
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// status, slot_index, payload_out, cert_bytes_out, ticket_bytes_out,
	// zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic [30:0] lifetime_q;
	logic        clearing;
	logic        push;
	logic        full;
	logic        pop;
	logic        empty;
	job_t        push_data;
	job_t        pop_data;
	out_word_t   out_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_wr_en) begin
			lifetime_q <= cfg_wr_data;
		end
	end

	scdm_front #(
		.CERT_MAX_BYTES   (CERT_MAX_BYTES),
		.TICKET_MAX_BYTES (TICKET_MAX_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser[0]),
		.in_word   (in_word_t'(s_axis_tdata)),
		.blocked   (clearing),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	scdm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	scdm_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lifetime  (lifetime_q),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word),
		.clearing  (clearing)
	);

	assign m_axis_tdata = out_word;

endmodule

`default_nettype wire

// ===== design/scdm_checker.sv =====
// ----------------------------------------------------------------------------
// session cache checker
// port-level properties of the session cache, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "session_cache_direct_mapped_ttl_unit_macros.svh"

module scdm_checker
	import scdm_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	out_word_t res;

	assign res = out_word_t'(m_axis_tdata);

	// a stalled result word holds
	`SCDM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// the front hashes one word at a time
	`SCDM_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready)

	// only a hit carries stored data
	`SCDM_ASSERT_SAME(a_miss_zero, clk, arst_n, m_axis_tvalid && res.status != ST_HIT,
		res.payload_out == 64'd0 && res.cert_bytes_out == 16'd0
		&& res.ticket_bytes_out == 16'd0)

	// no status beyond the ticket reject, and pad stays clear
	`SCDM_ASSERT_SAME(a_status_code, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[2:0] != 3'd7 && res.pad == 5'd0)

endmodule

bind session_cache_direct_mapped_ttl_unit scdm_checker u_scdm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/session_cache_direct_mapped_ttl_unit_test.sv =====
// ----------------------------------------------------------------------------
// session cache testbench
// drives store and lookup words through the stream ports and checks every
// reply against a slot table kept in the bench, over several lifetimes
// ----------------------------------------------------------------------------
`default_nettype none

module session_cache_direct_mapped_ttl_unit_test;
	import scdm_pkg::*;

	localparam int   SLOTS      = 256;
	localparam int   CERT_MAX   = 4096;
	localparam int   TICKET_MAX = 1024;
	localparam logic CMD_STORE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;
	localparam int   POOL_MAX   = 24;
	localparam int   PHASE_WORDS = 92;

	typedef struct {
		logic     cmd;
		in_word_t d;
		bit       pinned;   // status typed in by hand
		status_t  st;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [30:0]            cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// bench copy of the cache
	bit          slot_live [SLOTS];
	entry_t      slot_copy [SLOTS];
	logic [30:0] lifetime_cfg = LIFETIME_RESET;

	out_word_t   awaited_replies[$];
	in_word_t    stored_keys[$];
	logic [31:0] wall;
	bit          no_idle = 1'b0;
	int          errors = 0;
	int          words_sent = 0;
	int          status_count[8];

	session_cache_direct_mapped_ttl_unit #(
		.ENTRIES         (SLOTS),
		.CERT_MAX_BYTES  (CERT_MAX),
		.TICKET_MAX_BYTES(TICKET_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// works out the reply of one word and updates the slot table
	function automatic out_word_t cache_predict(logic cmd, in_word_t d);
		logic [255:0] key;
		logic [31:0]  h;
		logic [7:0]   idx;
		logic [32:0]  deadline;
		int           len;
		out_word_t    r;
		len = (d.key_length > 6'd32) ? 32 : int'(d.key_length);
		key = {d.key_word3, d.key_word2, d.key_word1, d.key_word0};
		for (int i = len; i < 32; i++)
			key[8*i +: 8] = 8'h00;
		// the suite is not hashed; the hash starts from the compression method
		h = 32'(d.compression_method) * HASH_MUL;
		for (int i = 0; i < len; i++)
			h = (h + 32'(key[8*i +: 8])) * HASH_MUL;
		idx = h[7:0];
		r = '0;
		r.slot_index = idx;
		if (cmd == CMD_STORE) begin
			if (d.cert_bytes_in > CERT_MAX) begin
				r.status = ST_CERT_BIG;
			end else if (d.ticket_bytes_in > TICKET_MAX) begin
				r.status = ST_TICKET_BIG;
			end else begin
				slot_live[idx] = 1'b1;
				slot_copy[idx].hash = h;
				slot_copy[idx].suite = d.cipher_suite;
				slot_copy[idx].comp = d.compression_method;
				slot_copy[idx].key_length = d.key_length;
				slot_copy[idx].key = key;
				slot_copy[idx].stamp = d.now_seconds;
				slot_copy[idx].payload = d.payload_in;
				slot_copy[idx].cert_bytes = d.cert_bytes_in;
				slot_copy[idx].ticket_bytes = d.ticket_bytes_in;
				r.status = ST_STORED;
			end
		end else if (!slot_live[idx] || slot_copy[idx].hash != h) begin
			r.status = ST_EMPTY;
		end else if (slot_copy[idx].suite != d.cipher_suite
				|| slot_copy[idx].comp != d.compression_method
				|| slot_copy[idx].key_length != d.key_length
				|| slot_copy[idx].key != key) begin
			r.status = ST_COLLISION;
		end else begin
			deadline = {1'b0, slot_copy[idx].stamp} + 33'(lifetime_cfg);
			if (d.now_seconds < slot_copy[idx].stamp || {1'b0, d.now_seconds} > deadline) begin
				slot_live[idx] = 1'b0;
				r.status = ST_EXPIRED;
			end else begin
				r.status = ST_HIT;
				r.payload_out = slot_copy[idx].payload;
				r.cert_bytes_out = slot_copy[idx].cert_bytes;
				r.ticket_bytes_out = slot_copy[idx].ticket_bytes;
			end
		end
		return r;
	endfunction

	function automatic stim_row_t row(logic cmd, logic [15:0] suite, logic [7:0] comp,
			logic [5:0] klen, logic [63:0] w, logic [31:0] now, logic [63:0] pay,
			logic [15:0] cert, logic [15:0] ticket, bit pinned, status_t st);
		stim_row_t s;
		s.cmd = cmd;
		s.d = '0;
		s.d.cipher_suite = suite;
		s.d.compression_method = comp;
		s.d.key_length = klen;
		s.d.key_word0 = w;
		s.d.key_word1 = w;
		s.d.key_word2 = w;
		s.d.key_word3 = w;
		s.d.now_seconds = now;
		s.d.payload_in = pay;
		s.d.cert_bytes_in = cert;
		s.d.ticket_bytes_in = ticket;
		s.pinned = pinned;
		s.st = st;
		return s;
	endfunction

	// sender side: idle gap, handshake, then queue the predicted reply
	task automatic send_word(logic cmd, in_word_t d, bit pinned, status_t st);
		int        gap;
		out_word_t r;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = cache_predict(cmd, d);
		if (pinned)
			r.status = st;
		awaited_replies.push_back(r);
		words_sent++;
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_lifetime(logic [30:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lifetime_cfg = v;
	endtask

	// mostly stores and lookups of remembered keys, some noise
	task automatic make_word(output logic cmd, output in_word_t d);
		int           pick;
		int           k;
		int           len;
		int           b;
		logic [255:0] key;
		logic [31:0]  stamp;
		logic [31:0]  span;
		pick = $urandom_range(0, 99);
		if (pick >= 45 && stored_keys.size() == 0)
			pick = 20;
		d = '0;
		if (pick < 10) begin
			cmd = 1'($urandom);
			d.cipher_suite = 16'($urandom);
			d.compression_method = 8'($urandom);
			d.key_length = 6'($urandom_range(0, 63));
			d.key_word0 = {$urandom, $urandom};
			d.key_word1 = {$urandom, $urandom};
			d.key_word2 = {$urandom, $urandom};
			d.key_word3 = {$urandom, $urandom};
			d.now_seconds = $urandom;
			d.payload_in = {$urandom, $urandom};
			d.cert_bytes_in = 16'($urandom);
			d.ticket_bytes_in = 16'($urandom);
		end else if (pick < 45) begin
			cmd = CMD_STORE;
			k = -1;
			if (stored_keys.size() != 0 && $urandom_range(0, 9) < 4) begin
				k = $urandom_range(0, stored_keys.size() - 1);
				d = stored_keys[k];
			end else begin
				d.cipher_suite = 16'($urandom);
				d.compression_method = 8'($urandom);
				d.key_length = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
					: 6'($urandom_range(0, 32));
				d.key_word0 = {$urandom, $urandom};
				d.key_word1 = {$urandom, $urandom};
				d.key_word2 = {$urandom, $urandom};
				d.key_word3 = {$urandom, $urandom};
			end
			d.now_seconds = wall;
			wall = wall + $urandom_range(0, 40);
			d.payload_in = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: d.cert_bytes_in = 16'd0;
				1: d.cert_bytes_in = 16'(CERT_MAX);
				2: d.cert_bytes_in = 16'(CERT_MAX + 1);
				3: d.cert_bytes_in = 16'($urandom_range(CERT_MAX + 1, 65535));
				default: d.cert_bytes_in = 16'($urandom_range(0, CERT_MAX));
			endcase
			case ($urandom_range(0, 9))
				0: d.ticket_bytes_in = 16'd0;
				1: d.ticket_bytes_in = 16'(TICKET_MAX);
				2: d.ticket_bytes_in = 16'(TICKET_MAX + 1);
				3: d.ticket_bytes_in = 16'($urandom_range(TICKET_MAX + 1, 65535));
				default: d.ticket_bytes_in = 16'($urandom_range(0, TICKET_MAX));
			endcase
			if (k >= 0)
				stored_keys[k] = d;
			else if (stored_keys.size() < POOL_MAX)
				stored_keys.push_back(d);
			else
				stored_keys[$urandom_range(0, POOL_MAX - 1)] = d;
		end else begin
			cmd = CMD_LOOKUP;
			d = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			stamp = d.now_seconds;
			// payload and lengths are don't-care on a lookup
			d.payload_in = {$urandom, $urandom};
			d.cert_bytes_in = 16'($urandom);
			d.ticket_bytes_in = 16'($urandom);
			span = (lifetime_cfg > 31'd1000) ? 32'd1000 : 32'(lifetime_cfg);
			case ($urandom_range(0, 7))
				0: d.now_seconds = stamp;
				1: d.now_seconds = stamp + 32'(lifetime_cfg);
				2: d.now_seconds = stamp + 32'(lifetime_cfg) + 32'd1;
				3: d.now_seconds = stamp - 32'($urandom_range(1, 4));
				6: d.now_seconds = $urandom;
				7: d.now_seconds = wall;
				default: d.now_seconds = stamp + $urandom_range(0, span);
			endcase
			case ($urandom_range(0, 9))
				0: d.cipher_suite = d.cipher_suite ^ 16'($urandom_range(1, 65535));
				1: begin
					len = (d.key_length > 6'd32) ? 32 : int'(d.key_length);
					if (len == 32) begin
						// same hash, different length
						d.key_length = 6'($urandom_range(32, 63));
					end else begin
						// bytes past the key length must not matter
						key = {d.key_word3, d.key_word2, d.key_word1, d.key_word0};
						b = $urandom_range(len, 31);
						key[8*b +: 8] = ~key[8*b +: 8];
						{d.key_word3, d.key_word2, d.key_word1, d.key_word0} = key;
					end
				end
				2: d.compression_method = d.compression_method ^ 8'h01;
				default: ;
			endcase
		end
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver side
	initial begin
		int        gap;
		out_word_t got;
		out_word_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got = m_axis_tdata;
			if (awaited_replies.size() == 0) begin
				$display("%0t: reply word with none outstanding, actual %h", $time, got);
				errors++;
			end else begin
				want = awaited_replies.pop_front();
				status_count[want.status]++;
				check_field("status", 64'(want.status), 64'(got.status));
				check_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
				check_field("payload_out", want.payload_out, got.payload_out);
				check_field("cert_bytes_out", 64'(want.cert_bytes_out), 64'(got.cert_bytes_out));
				check_field("ticket_bytes_out", 64'(want.ticket_bytes_out),
					64'(got.ticket_bytes_out));
				check_field("pad", 64'(want.pad), 64'(got.pad));
			end
		end
	end

	initial begin
		stim_row_t   script[$];
		logic [30:0] life_plan[6];
		logic        cmd;
		in_word_t    d;
		script.push_back(row(CMD_LOOKUP, 16'h0000, 8'h00, 6'd0, 64'h0, 32'd0, 64'h0,
			16'd0, 16'd0, 1, ST_EMPTY));
		script.push_back(row(CMD_STORE, 16'h1301, 8'h00, 6'd0, 64'h0, 32'd1000, 64'h1,
			16'd0, 16'd0, 1, ST_STORED));
		script.push_back(row(CMD_LOOKUP, 16'h1301, 8'h00, 6'd0, 64'h0, 32'd1000, 64'h0,
			16'd0, 16'd0, 0, ST_HIT));
		script.push_back(row(CMD_LOOKUP, 16'h1302, 8'h00, 6'd0, 64'h0, 32'd1000, 64'h0,
			16'd0, 16'd0, 1, ST_COLLISION));
		// last second of the default lifetime, then one past it
		script.push_back(row(CMD_LOOKUP, 16'h1301, 8'h00, 6'd0, 64'h0, 32'd87400, 64'h0,
			16'd0, 16'd0, 0, ST_HIT));
		script.push_back(row(CMD_LOOKUP, 16'h1301, 8'h00, 6'd0, 64'h0, 32'd87401, 64'h0,
			16'd0, 16'd0, 1, ST_EXPIRED));
		script.push_back(row(CMD_LOOKUP, 16'h1301, 8'h00, 6'd0, 64'h0, 32'd1000, 64'h0,
			16'd0, 16'd0, 1, ST_EMPTY));
		script.push_back(row(CMD_STORE, 16'h0001, 8'h03, 6'd4, 64'h1234, 32'd10, 64'h2,
			16'd4097, 16'd0, 1, ST_CERT_BIG));
		script.push_back(row(CMD_STORE, 16'h0001, 8'h03, 6'd4, 64'h1234, 32'd10, 64'h2,
			16'd4097, 16'd1025, 1, ST_CERT_BIG));
		script.push_back(row(CMD_STORE, 16'h0001, 8'h03, 6'd4, 64'h1234, 32'd10, 64'h2,
			16'd4096, 16'd1025, 1, ST_TICKET_BIG));
		script.push_back(row(CMD_STORE, 16'h0001, 8'h03, 6'd4, 64'h1234, 32'd10, 64'h2,
			16'hffff, 16'd0, 1, ST_CERT_BIG));
		script.push_back(row(CMD_STORE, 16'h0001, 8'h03, 6'd4, 64'h1234, 32'd10, 64'h2,
			16'd0, 16'hffff, 1, ST_TICKET_BIG));
		script.push_back(row(CMD_STORE, 16'hffff, 8'hff, 6'd32, '1, 32'hffff_ffff, '1,
			16'd4096, 16'd1024, 1, ST_STORED));
		script.push_back(row(CMD_LOOKUP, 16'hffff, 8'hff, 6'd32, '1, 32'hffff_ffff, 64'h0,
			16'd0, 16'd0, 0, ST_HIT));
		// same hash as the 32 byte key, length compared as given
		script.push_back(row(CMD_LOOKUP, 16'hffff, 8'hff, 6'd33, '1, 32'hffff_ffff, 64'h0,
			16'd0, 16'd0, 1, ST_COLLISION));
		script.push_back(row(CMD_LOOKUP, 16'hffff, 8'hff, 6'd32, '1, 32'hffff_fffe, 64'h0,
			16'd0, 16'd0, 1, ST_EXPIRED));
		script.push_back(row(CMD_STORE, 16'hffff, 8'hff, 6'd63, '1, 32'd0, 64'h5555_aaaa_5555_aaaa,
			16'd1, 16'd1, 1, ST_STORED));
		script.push_back(row(CMD_LOOKUP, 16'hffff, 8'hff, 6'd63, '1, 32'd86400, 64'h0,
			16'd0, 16'd0, 0, ST_HIT));
		script.push_back(row(CMD_STORE, 16'h002f, 8'h07, 6'd5, 64'haaaa_bb33_4455_6677,
			32'd5000, 64'h0123_4567_89ab_cdef, 16'd100, 16'd200, 1, ST_STORED));
		// differs only past the fifth id byte
		script.push_back(row(CMD_LOOKUP, 16'h002f, 8'h07, 6'd5, 64'h1111_2233_4455_6677,
			32'd5001, 64'h0, 16'd0, 16'd0, 0, ST_HIT));
		// rejected store leaves the old entry alone
		script.push_back(row(CMD_STORE, 16'h002f, 8'h07, 6'd5, 64'haaaa_bb33_4455_6677,
			32'd6000, 64'hdead_0000_beef_0000, 16'd5000, 16'd0, 1, ST_CERT_BIG));
		script.push_back(row(CMD_LOOKUP, 16'h002f, 8'h07, 6'd5, 64'haaaa_bb33_4455_6677,
			32'd6000, 64'h0, 16'd0, 16'd0, 0, ST_HIT));
		script.push_back(row(CMD_LOOKUP, 16'h002f, 8'h07, 6'd5, 64'haaaa_bb33_4455_6677,
			32'd4999, 64'h0, 16'd0, 16'd0, 1, ST_EXPIRED));
		script.push_back(row(CMD_STORE, 16'h0000, 8'h01, 6'd1, 64'h42, 32'hffff_ff00,
			64'h77, 16'd9, 16'd9, 1, ST_STORED));
		// stamp plus lifetime runs past 32 bits
		script.push_back(row(CMD_LOOKUP, 16'h0000, 8'h01, 6'd1, 64'h42, 32'hffff_ffff,
			64'h0, 16'd0, 16'd0, 0, ST_HIT));

		life_plan[0] = 31'd0;
		life_plan[1] = 31'd1;
		life_plan[2] = 31'h7fff_ffff;
		life_plan[3] = 31'd100;
		life_plan[4] = 31'($urandom_range(2, 3000));
		life_plan[5] = 31'($urandom);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_word(script[i].cmd, script[i].d, script[i].pinned, script[i].st);

		for (int p = 0; p < 6; p++) begin
			drain_replies();
			write_lifetime(life_plan[p]);
			no_idle = (p == 2);
			wall = $urandom;
			repeat (PHASE_WORDS) begin
				make_word(cmd, d);
				send_word(cmd, d, 0, ST_STORED);
			end
		end
		drain_replies();
		no_idle = 1'b0;
		repeat (60) @(posedge clk);

		$display("run covered %0d words over 7 lifetime settings including 0 and the maximum",
			words_sent);
		$display("replies: %0d stored, %0d hit, %0d empty, %0d collision, %0d expired, %0d rejected",
			status_count[ST_STORED], status_count[ST_HIT], status_count[ST_EMPTY],
			status_count[ST_COLLISION], status_count[ST_EXPIRED],
			status_count[ST_CERT_BIG] + status_count[ST_TICKET_BIG]);
		if (errors == 0) begin
			$display("session_cache_direct_mapped_ttl_unit_test passed");
		end else begin
			$display("session_cache_direct_mapped_ttl_unit_test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("session_cache_direct_mapped_ttl_unit_test failed");
		$finish;
	end

endmodule

`default_nettype wire
